### rtl/spa_pkg.sv
package spa_pkg;

   localparam int EXP_WIDTH = 16;
   localparam int OUT_COEF_WIDTH = 32;

   // request codes
   localparam logic [1:0] REQ_ADD   = 2'd0;
   localparam logic [1:0] REQ_DUMP  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   // response status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_FULL    = 2'd1;
   localparam logic [1:0] STAT_EMPTY   = 2'd2;
   localparam logic [1:0] STAT_CLEARED = 2'd3;

   // operation broadcast to every cell of the chain
   typedef enum logic [2:0] {
      CELL_HOLD    = 3'd0,
      CELL_COMPARE = 3'd1,
      CELL_MERGE   = 3'd2,
      CELL_REMOVE  = 3'd3,
      CELL_INSERT  = 3'd4,
      CELL_ROTATE  = 3'd5,
      CELL_CLEAR   = 3'd6
   } cell_op_type;

   // per cell compare results, seen by the controller and the right neighbor
   typedef struct packed {
      logic gt;
      logic eq;
      logic sum_zero;
   } cell_flag_type;

endpackage

### rtl/spa_cell.sv
module spa_cell #(
   parameter int COEF_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  spa_pkg::cell_op_type                  cell_op,
   input  logic signed [COEF_WIDTH-1:0]          bcast_coef,
   input  logic signed [spa_pkg::EXP_WIDTH-1:0]  bcast_exp,
   input  logic                                  left_valid,
   input  logic signed [COEF_WIDTH-1:0]          left_coef,
   input  logic signed [spa_pkg::EXP_WIDTH-1:0]  left_exp,
   input  logic                                  left_gt,
   input  logic                                  right_valid,
   input  logic signed [COEF_WIDTH-1:0]          right_coef,
   input  logic signed [spa_pkg::EXP_WIDTH-1:0]  right_exp,
   input  logic signed [COEF_WIDTH-1:0]          head_coef,
   input  logic signed [spa_pkg::EXP_WIDTH-1:0]  head_exp,
   output logic                                  entry_valid,
   output logic signed [COEF_WIDTH-1:0]          entry_coef,
   output logic signed [spa_pkg::EXP_WIDTH-1:0]  entry_exp,
   output spa_pkg::cell_flag_type                flag
);

   logic                                 valid_ff, valid_in;
   logic signed [COEF_WIDTH-1:0]         coef_ff, coef_in;
   logic signed [spa_pkg::EXP_WIDTH-1:0] exp_ff, exp_in;
   logic                                 gt_ff, gt_in;
   logic                                 eq_ff, eq_in;
   logic signed [COEF_WIDTH-1:0]         sum_ff, sum_in;

   always_comb begin
      valid_in = valid_ff;
      coef_in  = coef_ff;
      exp_in   = exp_ff;
      gt_in    = gt_ff;
      eq_in    = eq_ff;
      sum_in   = sum_ff;
      case (cell_op)
         spa_pkg::CELL_COMPARE: begin
            gt_in  = valid_ff && (exp_ff > bcast_exp);
            eq_in  = valid_ff && (exp_ff == bcast_exp);
            sum_in = coef_ff + bcast_coef;
         end
         spa_pkg::CELL_MERGE: begin
            if (eq_ff) begin
               coef_in = sum_ff;
            end
         end
         spa_pkg::CELL_REMOVE: begin
            // entries at and after the match slide one place left
            if (!gt_ff) begin
               valid_in = right_valid;
               coef_in  = right_coef;
               exp_in   = right_exp;
            end
         end
         spa_pkg::CELL_INSERT: begin
            // entries at and after the slot slide one place right
            if (!gt_ff) begin
               if (left_gt) begin
                  valid_in = 1'b1;
                  coef_in  = bcast_coef;
                  exp_in   = bcast_exp;
               end else begin
                  valid_in = left_valid;
                  coef_in  = left_coef;
                  exp_in   = left_exp;
               end
            end
         end
         spa_pkg::CELL_ROTATE: begin
            // last valid cell wraps around to the head
            if (valid_ff) begin
               if (right_valid) begin
                  coef_in = right_coef;
                  exp_in  = right_exp;
               end else begin
                  coef_in = head_coef;
                  exp_in  = head_exp;
               end
            end
         end
         spa_pkg::CELL_CLEAR: begin
            valid_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      coef_ff <= coef_in;
      exp_ff  <= exp_in;
      gt_ff   <= gt_in;
      eq_ff   <= eq_in;
      sum_ff  <= sum_in;
   end

   assign entry_valid   = valid_ff;
   assign entry_coef    = coef_ff;
   assign entry_exp     = exp_ff;
   assign flag.gt       = gt_ff;
   assign flag.eq       = eq_ff;
   assign flag.sum_zero = (sum_ff == '0);

endmodule

### rtl/sparse_polynomial_accumulator_core.sv
// Sorted table of polynomial terms held in a chain of cells, one term per cell,
// ordered by descending exponent from cell 0. A transaction is accepted when
// start is high and busy is low. In an add, in the accept cycle every cell
// compares its exponent with the new one and precomputes its sum, and in the
// next cycle the cells merge, remove or shift in the term together and the
// status result is issued. A clear, a dump of an empty table, an add with
// zero coefficient and the unused request code end in the accept cycle. In a
// dump of n terms the chain rotates one place per cycle and the term at
// its head is emitted each cycle, so the table is back in order at the end.
// Every result is on the rsp_ ports for exactly one cycle, marked by
// rsp_strobe; the receiver cannot stall the block, so it must take a result
// on every cycle in which rsp_strobe is high.
module sparse_polynomial_accumulator_core #(
   parameter int MAX_TERMS  = 16,
   parameter int COEF_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_type,
   input  logic signed [31:0] req_term_coef,
   input  logic signed [15:0] req_term_exp,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_out_coef,
   output logic signed [15:0] rsp_out_exp,
   output logic               rsp_is_last,
   output logic [1:0]         rsp_status
);

   localparam int CNT_W = $clog2(MAX_TERMS + 1);

   // controller states
   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_UPDATE = 3'b010,
      S_DUMP   = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] remain_ff, remain_in;

   // latched add term, broadcast during the update cycle
   logic signed [COEF_WIDTH-1:0]         add_coef_ff, add_coef_in;
   logic signed [spa_pkg::EXP_WIDTH-1:0] add_exp_ff, add_exp_in;

   // response registers
   logic                                 strobe_ff, strobe_in;
   logic signed [31:0]                   coef_ff, coef_in;
   logic signed [15:0]                   exp_ff, exp_in;
   logic                                 last_ff, last_in;
   logic [1:0]                           status_ff, status_in;

   logic                                 accept;
   logic signed [COEF_WIDTH-1:0]         req_coef_red;
   logic signed [COEF_WIDTH-1:0]         bcast_coef;
   logic signed [spa_pkg::EXP_WIDTH-1:0] bcast_exp;
   spa_pkg::cell_op_type                 cell_op;

   // chain signals
   logic [MAX_TERMS-1:0]                 cell_valid;
   logic signed [COEF_WIDTH-1:0]         cell_coef [MAX_TERMS];
   logic signed [spa_pkg::EXP_WIDTH-1:0] cell_exp  [MAX_TERMS];
   spa_pkg::cell_flag_type               cell_flag [MAX_TERMS];
   logic [MAX_TERMS-1:0]                 eq_vec;
   logic [MAX_TERMS-1:0]                 zero_vec;
   logic                                 any_eq;
   logic                                 eq_sum_zero;
   logic                                 full;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // coefficient reduced to the stored width, sign extended when wider
   assign req_coef_red = COEF_WIDTH'(req_term_coef);

   // compare against the ports in the accept cycle, insert the latched term later
   assign bcast_coef = (state_ff == S_IDLE) ? req_coef_red : add_coef_ff;
   assign bcast_exp  = (state_ff == S_IDLE) ? req_term_exp : add_exp_ff;

   genvar k;
   generate
      for (k = 0; k < MAX_TERMS; k++) begin : g_cell
         logic                                 left_valid;
         logic signed [COEF_WIDTH-1:0]         left_coef;
         logic signed [spa_pkg::EXP_WIDTH-1:0] left_exp;
         logic                                 left_gt;
         logic                                 right_valid;
         logic signed [COEF_WIDTH-1:0]         right_coef;
         logic signed [spa_pkg::EXP_WIDTH-1:0] right_exp;

         if (k == 0) begin : g_head
            // the head behaves as if a larger exponent sat to its left
            assign left_valid = 1'b0;
            assign left_coef  = '0;
            assign left_exp   = '0;
            assign left_gt    = 1'b1;
         end else begin : g_mid_left
            assign left_valid = cell_valid[k-1];
            assign left_coef  = cell_coef[k-1];
            assign left_exp   = cell_exp[k-1];
            assign left_gt    = cell_flag[k-1].gt;
         end

         if (k == MAX_TERMS - 1) begin : g_tail
            assign right_valid = 1'b0;
            assign right_coef  = '0;
            assign right_exp   = '0;
         end else begin : g_mid_right
            assign right_valid = cell_valid[k+1];
            assign right_coef  = cell_coef[k+1];
            assign right_exp   = cell_exp[k+1];
         end

         spa_cell #(
            .COEF_WIDTH (COEF_WIDTH)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .cell_op     (cell_op),
            .bcast_coef  (bcast_coef),
            .bcast_exp   (bcast_exp),
            .left_valid  (left_valid),
            .left_coef   (left_coef),
            .left_exp    (left_exp),
            .left_gt     (left_gt),
            .right_valid (right_valid),
            .right_coef  (right_coef),
            .right_exp   (right_exp),
            .head_coef   (cell_coef[0]),
            .head_exp    (cell_exp[0]),
            .entry_valid (cell_valid[k]),
            .entry_coef  (cell_coef[k]),
            .entry_exp   (cell_exp[k]),
            .flag        (cell_flag[k])
         );

         assign eq_vec[k]   = cell_flag[k].eq;
         assign zero_vec[k] = cell_flag[k].eq && cell_flag[k].sum_zero;
      end
   endgenerate

   // at most one cell matches since exponents are unique in the table
   assign any_eq      = |eq_vec;
   assign eq_sum_zero = |zero_vec;
   assign full        = (count_ff == CNT_W'(MAX_TERMS));

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      remain_in   = remain_ff;
      add_coef_in = add_coef_ff;
      add_exp_in  = add_exp_ff;
      cell_op     = spa_pkg::CELL_HOLD;
      strobe_in   = 1'b0;
      coef_in     = '0;
      exp_in      = '0;
      last_in     = 1'b1;
      status_in   = spa_pkg::STAT_OK;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_type)
                  spa_pkg::REQ_ADD: begin
                     if (req_coef_red == '0) begin
                        // zero term: acknowledge, table untouched
                        strobe_in = 1'b1;
                     end else begin
                        cell_op     = spa_pkg::CELL_COMPARE;
                        add_coef_in = req_coef_red;
                        add_exp_in  = req_term_exp;
                        state_in    = S_UPDATE;
                     end
                  end
                  spa_pkg::REQ_DUMP: begin
                     if (count_ff == '0) begin
                        strobe_in = 1'b1;
                        status_in = spa_pkg::STAT_EMPTY;
                     end else begin
                        remain_in = count_ff;
                        state_in  = S_DUMP;
                     end
                  end
                  spa_pkg::REQ_CLEAR: begin
                     cell_op   = spa_pkg::CELL_CLEAR;
                     count_in  = '0;
                     strobe_in = 1'b1;
                     status_in = spa_pkg::STAT_CLEARED;
                  end
                  default: begin
                     // unused request code gives no result
                  end
               endcase
            end
         end
         S_UPDATE: begin
            strobe_in = 1'b1;
            state_in  = S_IDLE;
            if (any_eq) begin
               if (eq_sum_zero) begin
                  cell_op  = spa_pkg::CELL_REMOVE;
                  count_in = count_ff - CNT_W'(1);
               end else begin
                  cell_op = spa_pkg::CELL_MERGE;
               end
            end else if (full) begin
               // new exponent with no room left: term dropped
               status_in = spa_pkg::STAT_FULL;
            end else begin
               cell_op  = spa_pkg::CELL_INSERT;
               count_in = count_ff + CNT_W'(1);
            end
         end
         S_DUMP: begin
            // emit the head and rotate the chain by one
            cell_op   = spa_pkg::CELL_ROTATE;
            strobe_in = 1'b1;
            coef_in   = 32'(cell_coef[0]);
            exp_in    = cell_exp[0];
            last_in   = (remain_ff == CNT_W'(1));
            remain_in = remain_ff - CNT_W'(1);
            if (remain_ff == CNT_W'(1)) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         remain_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         remain_ff <= remain_in;
         strobe_ff <= strobe_in;
      end
      add_coef_ff <= add_coef_in;
      add_exp_ff  <= add_exp_in;
      coef_ff     <= coef_in;
      exp_ff      <= exp_in;
      last_ff     <= last_in;
      status_ff   <= status_in;
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_out_coef = coef_ff;
   assign rsp_out_exp  = exp_ff;
   assign rsp_is_last  = last_ff;
   assign rsp_status   = status_ff;

   // term count tracks the occupied cells
   assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == int'(count_ff))
      else $error("term count does not match occupied cells");

   // occupied cells form a prefix of the chain
   assert property (@(posedge clock) disable iff (reset)
      ((cell_valid + MAX_TERMS'(1)) & cell_valid) == '0)
      else $error("gap in the cell chain");

   // a dump never runs past the stored terms
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DUMP) |-> (remain_ff != '0) && (remain_ff <= count_ff))
      else $error("dump counter out of range");

   // a dropped term only happens on a full table
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPDATE) && !any_eq && !full |=>
         rsp_strobe && (rsp_status == spa_pkg::STAT_OK))
      else $error("insert reported wrong status");

endmodule

### test/sparse_polynomial_accumulator_core_test.sv
module sparse_polynomial_accumulator_core_test;

   // request code that the block ignores
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   localparam int TABLE_DEPTH   = 16;
   localparam int RANDOM_ITEMS  = 300;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_CYCLES  = 40;
   localparam int REPORT_LIMIT  = 10;
   // no idling while the item count is inside this window
   localparam int QUIET_FIRST   = 150;
   localparam int QUIET_LAST    = 260;

   // one result transaction, as seen on the rsp_ ports
   typedef struct packed {
      logic signed [31:0] coef;
      logic signed [15:0] exp;
      logic               last;
      logic [1:0]         status;
   } term_rsp_type;

   // one row of the directed table
   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] coef;
      logic signed [15:0] exp;
      logic               typed;
      term_rsp_type       want;
   } stim_row_type;

   localparam term_rsp_type ACK_OK      = '{32'sd0, 16'sd0, 1'b1, spa_pkg::STAT_OK};
   localparam term_rsp_type ACK_FULL    = '{32'sd0, 16'sd0, 1'b1, spa_pkg::STAT_FULL};
   localparam term_rsp_type ACK_EMPTY   = '{32'sd0, 16'sd0, 1'b1, spa_pkg::STAT_EMPTY};
   localparam term_rsp_type ACK_CLEARED = '{32'sd0, 16'sd0, 1'b1, spa_pkg::STAT_CLEARED};
   localparam term_rsp_type NO_RSP      = '{32'sd0, 16'sd0, 1'b0, spa_pkg::STAT_OK};

   localparam int DIRECTED_COUNT = 25;

   // directed part: typed results only where they are obvious, the rest predicted
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{spa_pkg::REQ_DUMP,  32'sd0,        16'sd0,      1'b1, ACK_EMPTY},   // empty dump
      '{spa_pkg::REQ_ADD,   32'sd0,        16'sd5,      1'b1, ACK_OK},      // zero coefficient
      '{REQ_UNUSED,         32'sd0,        16'sd0,      1'b0, NO_RSP},      // unused code
      '{spa_pkg::REQ_ADD,   32'h7fff_ffff, 16'sh7fff,   1'b1, ACK_OK},      // top exp, max coef
      '{spa_pkg::REQ_ADD,   32'h8000_0000, 16'sh8000,   1'b1, ACK_OK},      // bottom exp, min
      '{spa_pkg::REQ_ADD,   32'sd1,        16'sd0,      1'b0, NO_RSP},
      '{spa_pkg::REQ_ADD,   -32'sd1,       16'sd100,    1'b0, NO_RSP},
      '{spa_pkg::REQ_ADD,   32'sd5,        -16'sd100,   1'b0, NO_RSP},
      '{spa_pkg::REQ_ADD,   32'sd17,       16'sd5,      1'b0, NO_RSP},
      '{spa_pkg::REQ_ADD,   -32'sd9,       -16'sd5,     1'b0, NO_RSP},
      '{spa_pkg::REQ_ADD,   32'sd1000,     16'sd1000,   1'b0, NO_RSP},
      '{spa_pkg::REQ_ADD,   -32'sd77,      -16'sd1000,  1'b0, NO_RSP},
      '{spa_pkg::REQ_ADD,   32'sd3,        16'sd7,      1'b0, NO_RSP},
      '{spa_pkg::REQ_ADD,   32'sd12345,    16'sd3,      1'b0, NO_RSP},
      '{spa_pkg::REQ_ADD,   -32'sd2,       -16'sd3,     1'b0, NO_RSP},
      '{spa_pkg::REQ_ADD,   32'sd20000,    16'sd20000,  1'b0, NO_RSP},
      '{spa_pkg::REQ_ADD,   -32'sd20000,   -16'sd20000, 1'b0, NO_RSP},
      '{spa_pkg::REQ_ADD,   32'sd42,       16'sd1,      1'b0, NO_RSP},
      '{spa_pkg::REQ_ADD,   32'h0f0f_0f0f, -16'sd1,     1'b0, NO_RSP},      // table now full
      '{spa_pkg::REQ_ADD,   32'sd99,       16'sd2,      1'b1, ACK_FULL},    // new exp dropped
      '{spa_pkg::REQ_ADD,   32'sd1,        16'sh7fff,   1'b1, ACK_OK},      // merge while full
      '{spa_pkg::REQ_ADD,   32'h8000_0000, 16'sh8000,   1'b1, ACK_OK},      // sum wraps to zero
      '{spa_pkg::REQ_DUMP,  32'sd0,        16'sd0,      1'b0, NO_RSP},
      '{spa_pkg::REQ_CLEAR, 32'sd0,        16'sd0,      1'b1, ACK_CLEARED},
      '{spa_pkg::REQ_DUMP,  32'sd0,        16'sd0,      1'b1, ACK_EMPTY}    // empty again
   };

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_type;
   logic signed [31:0] req_term_coef;
   logic signed [15:0] req_term_exp;
   logic               rsp_strobe;
   logic signed [31:0] rsp_out_coef;
   logic signed [15:0] rsp_out_exp;
   logic               rsp_is_last;
   logic [1:0]         rsp_status;

   // predicted polynomial, descending exponent from index 0
   logic signed [31:0] poly_coef [TABLE_DEPTH];
   logic signed [15:0] poly_exp  [TABLE_DEPTH];
   int                 poly_count;

   // results still to come, oldest first
   term_rsp_type       pending_terms [$];

   int                 mismatches;
   int                 items_sent;
   int                 cycle_count;
   term_rsp_type       got_term;
   term_rsp_type       want_term;

   sparse_polynomial_accumulator_core DUT (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_type      (req_type),
      .req_term_coef (req_term_coef),
      .req_term_exp  (req_term_exp),
      .rsp_strobe    (rsp_strobe),
      .rsp_out_coef  (rsp_out_coef),
      .rsp_out_exp   (rsp_out_exp),
      .rsp_is_last   (rsp_is_last),
      .rsp_status    (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // merge one request into the predicted table and queue its results
   task automatic accumulate_request(input logic [1:0] kind,
                                     input logic signed [31:0] coef,
                                     input logic signed [15:0] exp,
                                     input bit queue_results);
      logic signed [31:0] sum;
      logic [1:0]         add_status;
      int                 slot;
      add_status = spa_pkg::STAT_OK;
      case (kind)
         spa_pkg::REQ_ADD: begin
            if (coef != 32'sd0) begin
               slot = 0;
               while (slot < poly_count && poly_exp[slot] > exp) slot++;
               if (slot < poly_count && poly_exp[slot] == exp) begin
                  // same exponent: combine, drop the entry when it cancels
                  sum = poly_coef[slot] + coef;
                  if (sum == 32'sd0) begin
                     for (int k = slot; k < poly_count - 1; k++) begin
                        poly_coef[k] = poly_coef[k + 1];
                        poly_exp[k]  = poly_exp[k + 1];
                     end
                     poly_count--;
                  end else begin
                     poly_coef[slot] = sum;
                  end
               end else if (poly_count >= TABLE_DEPTH) begin
                  add_status = spa_pkg::STAT_FULL;
               end else begin
                  for (int k = poly_count; k > slot; k--) begin
                     poly_coef[k] = poly_coef[k - 1];
                     poly_exp[k]  = poly_exp[k - 1];
                  end
                  poly_coef[slot] = coef;
                  poly_exp[slot]  = exp;
                  poly_count++;
               end
            end
            if (queue_results)
               pending_terms.push_back('{32'sd0, 16'sd0, 1'b1, add_status});
         end
         spa_pkg::REQ_DUMP: begin
            if (queue_results) begin
               if (poly_count == 0) begin
                  pending_terms.push_back(ACK_EMPTY);
               end else begin
                  for (int k = 0; k < poly_count; k++)
                     pending_terms.push_back('{poly_coef[k], poly_exp[k],
                                               k == poly_count - 1, spa_pkg::STAT_OK});
               end
            end
         end
         spa_pkg::REQ_CLEAR: begin
            poly_count = 0;
            if (queue_results) pending_terms.push_back(ACK_CLEARED);
         end
         default: ;  // unused code, no result
      endcase
   endtask

   // drive one request transaction and wait until the block takes it
   task automatic issue_request(input logic [1:0] kind,
                                input logic signed [31:0] coef,
                                input logic signed [15:0] exp,
                                input bit typed,
                                input term_rsp_type want);
      int gap;
      gap = 0;
      if (items_sent < QUIET_FIRST || items_sent >= QUIET_LAST)
         while ($urandom_range(0, 99) < 8) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_type      <= kind;
      req_term_coef <= coef;
      req_term_exp  <= exp;
      accumulate_request(kind, coef, exp, !typed);
      if (typed) pending_terms.push_back(want);
      items_sent++;
      // busy seen here is its value before the edge, the one that decides acceptance
      do @(posedge clock); while (busy);
   endtask

   // random coefficient: half the time small so sums cancel, else full width
   function automatic logic signed [31:0] pick_coef();
      logic signed [31:0] value;
      if ($urandom_range(0, 1) == 0) begin
         value = $urandom_range(1, 8);
         if ($urandom_range(0, 1) == 0) value = -value;
      end else begin
         value = $urandom;
      end
      return value;
   endfunction

   // result checker: every strobe is compared with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         got_term = '{rsp_out_coef, rsp_out_exp, rsp_is_last, rsp_status};
         if (pending_terms.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected result: coef %0d exp %0d last %0b status %0d",
                        got_term.coef, got_term.exp, got_term.last, got_term.status);
         end else begin
            want_term = pending_terms.pop_front();
            if (got_term !== want_term) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("mismatch: expected (%0d, %0d, %0b, %0d), got (%0d, %0d, %0b, %0d)",
                           want_term.coef, want_term.exp, want_term.last, want_term.status,
                           got_term.coef, got_term.exp, got_term.last, got_term.status);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sparse_polynomial_accumulator_core_test: done, errors");
         $finish;
      end
   end

   initial begin
      logic signed [15:0] exp_pool [24];
      logic signed [31:0] coef;
      logic signed [15:0] exp;
      logic [1:0]         kind;
      int                 pool_size;
      int                 episode_len;
      int                 roll;
      int                 pick;
      int                 random_count;

      reset         = 1'b1;
      start         = 1'b0;
      req_type      = spa_pkg::REQ_ADD;
      req_term_coef = 32'sd0;
      req_term_exp  = 16'sd0;
      poly_count    = 0;
      items_sent    = 0;
      random_count  = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int r = 0; r < DIRECTED_COUNT; r++)
         issue_request(DIRECTED_ROWS[r].kind, DIRECTED_ROWS[r].coef,
                       DIRECTED_ROWS[r].exp, DIRECTED_ROWS[r].typed,
                       DIRECTED_ROWS[r].want);

      // random episodes: a small exponent pool so terms collide, cancel and fill
      while (random_count < RANDOM_ITEMS) begin
         pool_size = $urandom_range(3, 24);
         for (int k = 0; k < pool_size; k++) exp_pool[k] = 16'($urandom);
         episode_len = $urandom_range(8, 40);
         for (int n = 0; n < episode_len; n++) begin
            roll = $urandom_range(0, 99);
            coef = 32'sd0;
            exp  = 16'sd0;
            if (roll < 6) begin
               kind = spa_pkg::REQ_DUMP;
            end else if (roll < 8) begin
               // noise: unused code with random payload
               kind = REQ_UNUSED;
               coef = $urandom;
               exp  = 16'($urandom);
            end else if (roll < 10) begin
               kind = spa_pkg::REQ_CLEAR;
               coef = $urandom;
               exp  = 16'($urandom);
            end else if (roll < 14) begin
               kind = spa_pkg::REQ_ADD;
               exp  = exp_pool[$urandom_range(0, pool_size - 1)];
            end else if (roll < 26 && poly_count > 0) begin
               // cancel a stored term exactly
               kind = spa_pkg::REQ_ADD;
               pick = $urandom_range(0, poly_count - 1);
               coef = -poly_coef[pick];
               exp  = poly_exp[pick];
            end else begin
               kind = spa_pkg::REQ_ADD;
               coef = pick_coef();
               if ($urandom_range(0, 9) == 0) exp = 16'($urandom);
               else exp = exp_pool[$urandom_range(0, pool_size - 1)];
            end
            issue_request(kind, coef, exp, 1'b0, NO_RSP);
            if (kind != REQ_UNUSED) random_count++;
         end
         issue_request(spa_pkg::REQ_DUMP, $urandom, 16'($urandom), 1'b0, NO_RSP);
         random_count++;
         if ($urandom_range(0, 1) == 0) begin
            issue_request(spa_pkg::REQ_CLEAR, 32'sd0, 16'sd0, 1'b0, NO_RSP);
            random_count++;
         end
      end
      start <= 1'b0;

      // drain, then give stray results time to show up
      while (pending_terms.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && pending_terms.size() == 0) begin
         $display("sparse_polynomial_accumulator_core_test: done, clean");
      end else begin
         $display("sparse_polynomial_accumulator_core_test: done, errors");
      end
      $finish;
   end

endmodule

### sim.f
rtl/spa_pkg.sv
rtl/spa_cell.sv
rtl/sparse_polynomial_accumulator_core.sv
test/sparse_polynomial_accumulator_core_test.sv
